// ===== src/brb_pkg.sv =====
// Shared constants, operation codes and command types for the byte ring buffer.
package brb_pkg;

  localparam int DEPTH_DEFAULT              = 1024;
  localparam int HEADER_BYTES_DEFAULT       = 8;
  localparam int LENGTH_FIELD_BYTES_DEFAULT = 4;

  localparam int OP_W        = 3;
  localparam int CNT_W       = 11;
  localparam int BYTE_W      = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] MLEN_MAX = '1;

  localparam logic [OP_W-1:0] OP_PUSH_BEGIN = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BYTE  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BEGIN  = 3'd2;
  localparam logic [OP_W-1:0] OP_MSG_BEGIN  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BYTE   = 3'd4;

  typedef enum logic [2:0] {
    CMD_PUSH_BEGIN,
    CMD_PUSH_BYTE,
    CMD_POP_BEGIN,
    CMD_MSG_BEGIN,
    CMD_POP_BYTE,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CNT_W-1:0]   count;
    logic [BYTE_W-1:0]  data;
    logic               consume;
  } cmd_t;

endpackage

// ===== src/brb_if.sv =====
// Request, response and configuration channel interfaces.
interface brb_req_if;
  import brb_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CNT_W-1:0]  count_or_limit;
  logic [BYTE_W-1:0] data_in;
  logic              consume;
  modport source(output valid, operation, count_or_limit, data_in, consume, input ready);
  modport sink(input valid, operation, count_or_limit, data_in, consume, output ready);
endinterface

interface brb_rsp_if;
  import brb_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [BYTE_W-1:0] data_out;
  logic              last_byte;
  logic [CNT_W-1:0]  message_length;
  logic [CNT_W-1:0]  bytes_held;
  modport source(output valid, status, data_out, last_byte, message_length, bytes_held,
                 input ready);
  modport sink(input valid, status, data_out, last_byte, message_length, bytes_held,
               output ready);
endinterface

interface brb_cfg_if;
  import brb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== src/byte_ring_buffer_with_message_pop.sv =====
// Top level of the circular byte buffer with length-prefixed message pop.
// Path: front stage register, command queue, back stage with registered response; pop byte
// adds the ST_POP state, message begin the ST_HDR states (one header byte read per cycle)
// and ST_CHECK. The back stage has a single storage read port and takes no new command while
// either is in progress; other items are taken one per cycle while responses are not stalled.
// Reset: pointers, counts and runs cleared, size set to DEPTH; storage is not cleared.
module byte_ring_buffer_with_message_pop #(
  parameter int DEPTH              = brb_pkg::DEPTH_DEFAULT,
  parameter int HEADER_BYTES       = brb_pkg::HEADER_BYTES_DEFAULT,
  parameter int LENGTH_FIELD_BYTES = brb_pkg::LENGTH_FIELD_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  brb_cfg_if.sink    cfg,
  brb_req_if.sink    req,
  brb_rsp_if.source  rsp
);
  import brb_pkg::*;

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  brb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .in_operation (req.operation),
    .in_count     (req.count_or_limit),
    .in_data      (req.data_in),
    .in_consume   (req.consume),
    .cmd_valid    (front_valid),
    .cmd_ready    (front_ready),
    .cmd          (front_cmd)
  );

  brb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  brb_back #(
    .DEPTH              (DEPTH),
    .HEADER_BYTES       (HEADER_BYTES),
    .LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_data   (cfg.data),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_data   (rsp.data_out),
    .rsp_last   (rsp.last_byte),
    .rsp_mlen   (rsp.message_length),
    .rsp_held   (rsp.bytes_held)
  );

endmodule

// ===== src/brb_front.sv =====
// Front stage: accepts request transactions and classifies them into commands.
module brb_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [brb_pkg::OP_W-1:0]   in_operation,
  input  logic [brb_pkg::CNT_W-1:0]  in_count,
  input  logic [brb_pkg::BYTE_W-1:0] in_data,
  input  logic                     in_consume,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output brb_pkg::cmd_t            cmd
);
  import brb_pkg::*;

  logic stage_valid;
  cmd_t stage_cmd;

  function automatic cmd_kind_t classify(input logic [OP_W-1:0] op);
    cmd_kind_t k;
    unique case (op)
      OP_PUSH_BEGIN: k = CMD_PUSH_BEGIN;
      OP_PUSH_BYTE:  k = CMD_PUSH_BYTE;
      OP_POP_BEGIN:  k = CMD_POP_BEGIN;
      OP_MSG_BEGIN:  k = CMD_MSG_BEGIN;
      OP_POP_BYTE:   k = CMD_POP_BYTE;
      default:       k = CMD_BAD;
    endcase
    return k;
  endfunction

  assign in_ready  = !stage_valid || cmd_ready;
  assign cmd_valid = stage_valid;
  assign cmd       = stage_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (cmd_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_cmd.kind    <= classify(in_operation);
      stage_cmd.count   <= in_count;
      stage_cmd.data    <= in_data;
      stage_cmd.consume <= in_consume;
    end
  end

endmodule

// ===== src/brb_queue.sv =====
// Short command queue between the front and back stages.
module brb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  brb_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output brb_pkg::cmd_t pop_cmd
);
  import brb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t              entries [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != (PW+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// ===== src/brb_back.sv =====
// Back stage: executes commands against the ring storage and registers results.
module brb_back #(
  parameter int DEPTH              = brb_pkg::DEPTH_DEFAULT,
  parameter int HEADER_BYTES       = brb_pkg::HEADER_BYTES_DEFAULT,
  parameter int LENGTH_FIELD_BYTES = brb_pkg::LENGTH_FIELD_BYTES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brb_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  brb_pkg::cmd_t              cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic                       rsp_status,
  output logic [brb_pkg::BYTE_W-1:0] rsp_data,
  output logic                       rsp_last,
  output logic [brb_pkg::CNT_W-1:0]  rsp_mlen,
  output logic [brb_pkg::CNT_W-1:0]  rsp_held
);
  import brb_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int SWR = $clog2(DEPTH + 1);
  localparam int SW  = (SWR > CNT_W) ? SWR : CNT_W;
  localparam int LW  = 8 * LENGTH_FIELD_BYTES;
  localparam int CW  = (LW > SW) ? LW : SW;
  localparam int KW  = (LENGTH_FIELD_BYTES > 1) ? $clog2(LENGTH_FIELD_BYTES) : 1;
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [SW-1:0] HEADER_S = SW'(HEADER_BYTES);
  localparam logic [KW-1:0] K_LAST   = KW'(LENGTH_FIELD_BYTES - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_HDR, ST_CHECK} state_t;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;

  state_t            state;
  logic [SW-1:0]     buf_size;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [SW-1:0]     held;
  logic [CNT_W-1:0]  push_rem;
  logic [AW-1:0]     read_idx;
  logic [SW-1:0]     pop_rem;
  logic              pop_cons;
  logic [AW-1:0]     hdr_idx;
  logic [KW-1:0]     hdr_k;
  logic [LW-1:0]     len_acc;
  logic [CNT_W-1:0]  cur_limit;

  logic              take;
  logic [AW-1:0]     hdr_idx_next;
  logic [AW-1:0]     read_idx_next;
  logic [SW-1:0]     cfg_size;
  logic [CW-1:0]     len_x;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] i,
                                              input logic [SW-1:0] size);
    logic [SW:0] n;
    n = (SW+1)'(i) + (SW+1)'(1);
    return (n >= (SW+1)'(size)) ? '0 : AW'(n);
  endfunction

  assign cfg_ready     = 1'b1;
  assign take          = (state == ST_IDLE) && cmd_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready     = take;
  assign hdr_idx_next  = wrap_next(hdr_idx, buf_size);
  assign read_idx_next = wrap_next(read_idx, buf_size);
  assign len_x         = CW'(len_acc);

  always_comb begin
    cfg_size = SW'(cfg_data);
    if (cfg_size == '0) cfg_size = SW'(1);
    if (cfg_size > DEPTH_S) cfg_size = DEPTH_S;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = read_idx;
    wr_en   = take && (cmd.kind == CMD_PUSH_BYTE) && (push_rem != '0);
    if (take && (cmd.kind == CMD_POP_BYTE) && (pop_rem != '0)) begin
      rd_en = 1'b1;
    end else if (take && (cmd.kind == CMD_MSG_BEGIN) && (held >= HEADER_S)) begin
      rd_en   = 1'b1;
      rd_addr = head;
    end else if ((state == ST_HDR) && (hdr_k != K_LAST)) begin
      rd_en   = 1'b1;
      rd_addr = hdr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[tail] <= cmd.data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      buf_size  <= DEPTH_S;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      push_rem  <= '0;
      read_idx  <= '0;
      pop_rem   <= '0;
      pop_cons  <= 1'b0;
    end else if (cfg_valid) begin
      state     <= ST_IDLE;
      buf_size  <= cfg_size;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      push_rem  <= '0;
      read_idx  <= '0;
      pop_rem   <= '0;
      pop_cons  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            rsp_status <= 1'b1;
            rsp_data   <= '0;
            rsp_last   <= 1'b0;
            rsp_mlen   <= '0;
            rsp_held   <= held[CNT_W-1:0];
            cur_limit  <= cmd.count;
            unique case (cmd.kind)
              CMD_PUSH_BEGIN: begin
                rsp_valid <= 1'b1;
                if (SW'(cmd.count) <= buf_size - held) begin
                  push_rem   <= cmd.count;
                  rsp_status <= 1'b0;
                end
              end
              CMD_PUSH_BYTE: begin
                rsp_valid <= 1'b1;
                if (push_rem != '0) begin
                  tail       <= wrap_next(tail, buf_size);
                  held       <= held + SW'(1);
                  push_rem   <= push_rem - CNT_W'(1);
                  rsp_held   <= CNT_W'(held + SW'(1));
                  rsp_status <= 1'b0;
                end
              end
              CMD_POP_BEGIN: begin
                rsp_valid <= 1'b1;
                if (SW'(cmd.count) <= held) begin
                  read_idx   <= head;
                  pop_rem    <= SW'(cmd.count);
                  pop_cons   <= cmd.consume;
                  rsp_status <= 1'b0;
                end
              end
              CMD_MSG_BEGIN: begin
                if (held >= HEADER_S) begin
                  hdr_idx <= head;
                  hdr_k   <= '0;
                  len_acc <= '0;
                  state   <= ST_HDR;
                end else begin
                  rsp_valid <= 1'b1;
                end
              end
              CMD_POP_BYTE: begin
                if (pop_rem != '0) begin
                  state <= ST_POP;
                end else begin
                  rsp_valid <= 1'b1;
                end
              end
              default: begin
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_POP: begin
          rsp_valid  <= 1'b1;
          rsp_status <= 1'b0;
          rsp_data   <= rd_data;
          rsp_last   <= pop_rem == SW'(1);
          read_idx   <= read_idx_next;
          pop_rem    <= pop_rem - SW'(1);
          if (pop_cons) begin
            head <= read_idx_next;
            if (held != '0) begin
              held     <= held - SW'(1);
              rsp_held <= CNT_W'(held - SW'(1));
            end
          end
          state <= ST_IDLE;
        end
        ST_HDR: begin
          len_acc[8*hdr_k +: 8] <= rd_data;
          if (hdr_k == K_LAST) begin
            state <= ST_CHECK;
          end else begin
            hdr_idx <= hdr_idx_next;
            hdr_k   <= hdr_k + KW'(1);
          end
        end
        ST_CHECK: begin
          rsp_valid <= 1'b1;
          rsp_mlen  <= (len_x > CW'(MLEN_MAX)) ? MLEN_MAX : CNT_W'(len_acc);
          if ((len_x != '0) && (len_x <= CW'(cur_limit)) && (len_x <= CW'(held))) begin
            read_idx   <= head;
            pop_rem    <= SW'(len_acc);
            pop_cons   <= 1'b1;
            rsp_status <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/byte_ring_buffer_with_message_pop_test.sv =====
// Self-checking testbench for the byte ring buffer: predicted replies vs. DUT, directed and random traffic.
`timescale 1ns / 100ps

module byte_ring_buffer_with_message_pop_test;
  import brb_pkg::*;

  localparam int RING_DEPTH    = DEPTH_DEFAULT;
  localparam int HDR_BYTES     = HEADER_BYTES_DEFAULT;
  localparam int LEN_BYTES     = LENGTH_FIELD_BYTES_DEFAULT;
  localparam int SETTLE_CYCLES = LENGTH_FIELD_BYTES_DEFAULT + 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 44;

  localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] data;
    logic              consume;
  } ring_req_t;

  typedef struct {
    ring_req_t req;
    int        gap;
  } queued_req_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] data;
    logic              last_flag;
    logic [CNT_W-1:0]  msg_len;
    logic [CNT_W-1:0]  held;
  } ring_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brb_cfg_if cfg_ch();
  brb_req_if req_ch();
  brb_rsp_if rsp_ch();

  byte_ring_buffer_with_message_pop DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the ring state
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int ring_size   = RING_DEPTH;
  int head_ptr    = 0;
  int tail_ptr    = 0;
  int held_bytes  = 0;
  int push_left   = 0;
  int rd_ptr      = 0;
  int pop_left    = 0;
  bit pop_removes = 1'b0;

  queued_req_t queued_requests[$];
  ring_reply_t pending_replies[$];
  int  fail_count  = 0;
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  burst_mode  = 1'b0;

  ring_req_t   taken_req;
  queued_req_t next_req;
  int          send_wait;
  ring_reply_t got_reply;
  ring_reply_t want_reply;
  int          stall_left;
  int          stall_draw;

  function automatic int ring_next(int i);
    return (i + 1 >= ring_size) ? 0 : i + 1;
  endfunction

  function automatic void resize_ring(logic [CNT_W-1:0] value);
    ring_size   = (value == 0) ? 1 : ((value > RING_DEPTH) ? RING_DEPTH : int'(value));
    head_ptr    = 0;
    tail_ptr    = 0;
    held_bytes  = 0;
    push_left   = 0;
    rd_ptr      = 0;
    pop_left    = 0;
    pop_removes = 1'b0;
  endfunction

  function automatic ring_reply_t predict_ring_reply(ring_req_t r);
    ring_reply_t res;
    logic [8*LEN_BYTES-1:0] hdr_len;
    int idx;
    res = '0;
    res.status = 1'b1;
    case (r.op)
      OP_PUSH_BEGIN: begin
        if (int'(r.count) <= ring_size - held_bytes) begin
          push_left  = int'(r.count);
          res.status = 1'b0;
        end
      end
      OP_PUSH_BYTE: begin
        if (push_left != 0) begin
          ring_mem[tail_ptr] = r.data;
          tail_ptr   = ring_next(tail_ptr);
          held_bytes++;
          push_left--;
          res.status = 1'b0;
        end
      end
      OP_POP_BEGIN: begin
        if (int'(r.count) <= held_bytes) begin
          rd_ptr      = head_ptr;
          pop_left    = int'(r.count);
          pop_removes = r.consume;
          res.status  = 1'b0;
        end
      end
      OP_MSG_BEGIN: begin
        if (held_bytes >= HDR_BYTES) begin
          hdr_len = '0;
          idx = head_ptr;
          for (int b = 0; b < LEN_BYTES; b++) begin
            hdr_len[8*b +: 8] = ring_mem[idx];
            idx = ring_next(idx);
          end
          res.msg_len = (hdr_len > MLEN_MAX) ? MLEN_MAX : hdr_len[CNT_W-1:0];
          if (hdr_len != 0 && hdr_len <= r.count && hdr_len <= held_bytes) begin
            rd_ptr      = head_ptr;
            pop_left    = int'(hdr_len);
            pop_removes = 1'b1;
            res.status  = 1'b0;
          end
        end
      end
      OP_POP_BYTE: begin
        if (pop_left != 0) begin
          res.data = ring_mem[rd_ptr];
          rd_ptr   = ring_next(rd_ptr);
          pop_left--;
          res.last_flag = (pop_left == 0);
          if (pop_removes) begin
            head_ptr = rd_ptr;
            if (held_bytes != 0) held_bytes--;
          end
          res.status = 1'b0;
        end
      end
      default: ;
    endcase
    res.held = CNT_W'(held_bytes);
    return res;
  endfunction

  function automatic int draw_gap();
    if (burst_mode || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_wait    <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken_req = '{req_ch.operation, req_ch.count_or_limit, req_ch.data_in, req_ch.consume};
        pending_replies.push_back(predict_ring_reply(taken_req));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (queued_requests.size() > 0 && send_wait >= queued_requests[0].gap) begin
          next_req = queued_requests.pop_front();
          req_ch.valid          <= 1'b1;
          req_ch.operation      <= next_req.req.op;
          req_ch.count_or_limit <= next_req.req.count;
          req_ch.data_in        <= next_req.req.data;
          req_ch.consume        <= next_req.req.consume;
          send_wait             <= 0;
        end else begin
          req_ch.valid <= 1'b0;
          if (queued_requests.size() > 0) send_wait <= send_wait + 1;
        end
      end
    end
  end

  // Reply monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      got_reply = '{rsp_ch.status, rsp_ch.data_out, rsp_ch.last_byte,
                    rsp_ch.message_length, rsp_ch.bytes_held};
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none actual %p", $time, got_reply);
        fail_count++;
      end else begin
        want_reply = pending_replies.pop_front();
        check_field("status", CNT_W'(want_reply.status), CNT_W'(got_reply.status));
        check_field("data_out", CNT_W'(want_reply.data), CNT_W'(got_reply.data));
        check_field("last_byte", CNT_W'(want_reply.last_flag), CNT_W'(got_reply.last_flag));
        check_field("message_length", want_reply.msg_len, got_reply.msg_len);
        check_field("bytes_held", want_reply.held, got_reply.held);
      end
      stall_draw = draw_gap();
      stall_left   <= stall_draw;
      rsp_ch.ready <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= (stall_left == 1);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(logic [OP_W-1:0] op, int count, int data, bit consume);
    queued_req_t q;
    q.req = '{op, CNT_W'(count), BYTE_W'(data), consume};
    q.gap = draw_gap();
    queued_requests.push_back(q);
    items_sent++;
  endtask

  task automatic wait_sent();
    while (queued_requests.size() != 0 || req_ch.valid) @(negedge clk);
  endtask

  task automatic wait_idle();
    while (queued_requests.size() != 0 || req_ch.valid || pending_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_size(logic [CNT_W-1:0] value);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    resize_ring(value);
  endtask

  task automatic drain_run(bit exact);
    int n;
    n = pop_left;
    if (!exact) begin
      case ($urandom_range(0, 9))
        0: if (n > 0) n--;
        1: n++;
        default: ;
      endcase
    end
    repeat (n) send(OP_POP_BYTE, $urandom_range(0, 1024), $urandom_range(0, 255),
                    1'($urandom_range(0, 1)));
  endtask

  task automatic flush_ring();
    send(OP_POP_BEGIN, held_bytes, $urandom_range(0, 255), 1'b1);
    wait_sent();
    drain_run(1'b1);
  endtask

  task automatic push_block();
    int room;
    int n;
    room = ring_size - held_bytes;
    n = (room > 0) ? $urandom_range(1, (room < 12) ? room : 12) : $urandom_range(1, 4);
    if (room > 0 && room <= 40 && $urandom_range(0, 4) == 0) n = room;
    send(OP_PUSH_BEGIN, n, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    wait_sent();
    n = push_left;
    case ($urandom_range(0, 9))
      0: if (n > 0) n--;
      1: n++;
      default: ;
    endcase
    repeat (n) send(OP_PUSH_BYTE, $urandom_range(0, 1024), $urandom_range(0, 255),
                    1'($urandom_range(0, 1)));
  endtask

  task automatic push_message();
    logic [8*LEN_BYTES-1:0] hdr;
    int room;
    int len;
    int n;
    room = ring_size - held_bytes;
    len = (room >= HDR_BYTES) ? $urandom_range(HDR_BYTES, (room < 40) ? room : 40) : HDR_BYTES;
    hdr = len;
    case ($urandom_range(0, 11))
      0: hdr = '0;
      1: hdr = $urandom;
      2: hdr = len + $urandom_range(1, 3);
      3: hdr = len - 1;
      default: ;
    endcase
    send(OP_PUSH_BEGIN, len, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    wait_sent();
    n = push_left;
    for (int i = 0; i < n; i++)
      send(OP_PUSH_BYTE, $urandom_range(0, 1024),
           (i < LEN_BYTES) ? int'(hdr[8*i +: 8]) : $urandom_range(0, 255),
           1'($urandom_range(0, 1)));
  endtask

  task automatic read_message();
    int limit;
    limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 48) : $urandom_range(48, 1024);
    send(OP_MSG_BEGIN, limit, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    wait_sent();
    drain_run(1'b0);
  endtask

  task automatic random_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    wait_sent();
    if (pick < 25) begin
      push_block();
    end else if (pick < 55) begin
      if (held_bytes != 0 && $urandom_range(0, 2) != 0) flush_ring();
      push_message();
      if ($urandom_range(0, 3) == 0) push_message();
      wait_sent();
      read_message();
    end else if (pick < 75) begin
      if (held_bytes < RING_DEPTH && $urandom_range(0, 5) == 0)
        n = held_bytes + 1;
      else
        n = $urandom_range(0, held_bytes);
      send(OP_POP_BEGIN, n, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      wait_sent();
      drain_run(1'b0);
    end else if (pick < 85) begin
      flush_ring();
    end else begin
      repeat ($urandom_range(1, 4))
        send(OP_W'($urandom_range(0, 7)),
             $urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom_range(0, 1024),
             $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random(int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) random_sequence();
  endtask

  initial begin
    logic [CNT_W-1:0] sizes [10];
    sizes = '{11'd0, 11'd16, 11'd2047, 11'd8, 11'd37, 11'd1, 11'd200, 11'd1023, 11'd9, 11'd64};
    cfg_ch.valid          = 1'b0;
    cfg_ch.data           = '0;
    req_ch.valid          = 1'b0;
    req_ch.operation      = OP_PUSH_BEGIN;
    req_ch.count_or_limit = '0;
    req_ch.data_in        = '0;
    req_ch.consume        = 1'b0;
    rsp_ch.ready          = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: runs absent, unknown codes, empty buffer, bad headers
    send(OP_POP_BYTE, 0, 8'h00, 1'b0);
    send(OP_PUSH_BYTE, 1024, 8'hFF, 1'b1);
    send(OP_UNUSED_5, 1023, 8'h00, 1'b1);
    send(OP_UNUSED_6, 0, 8'hFF, 1'b0);
    send(OP_UNUSED_7, 1024, 8'h55, 1'b1);
    send(OP_MSG_BEGIN, 1024, 8'h00, 1'b0);
    send(OP_POP_BEGIN, 1, 8'h00, 1'b1);
    send(OP_POP_BEGIN, 0, 8'h00, 1'b1);
    send(OP_POP_BYTE, 1023, 8'hFF, 1'b1);
    send(OP_PUSH_BEGIN, 1024, 8'h00, 1'b0);
    send(OP_PUSH_BEGIN, 0, 8'h00, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'hAA, 1'b0);
    send(OP_PUSH_BEGIN, 8, 8'h00, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'd9, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'h00, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'h00, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'h00, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'hFF, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'h5A, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'hA5, 1'b0);
    send(OP_PUSH_BYTE, 0, 8'h00, 1'b0);
    send(OP_MSG_BEGIN, 8, 8'h00, 1'b0);
    send(OP_MSG_BEGIN, 1024, 8'h00, 1'b0);

    run_random(PHASE_ITEMS);
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      burst_mode = (p % 3 == 1);
      if (p == 4) begin
        run_random(PHASE_ITEMS / 2);
        wait_idle();
        run_random(PHASE_ITEMS / 2);
      end else begin
        run_random(PHASE_ITEMS);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
